// ----- rtl/tcf_pkg.sv -----
// ----------------------------------------------------------------------------
// Track confirmation package
// Shared types, register indexes, reset values and state codes for the
// per-frame track manager.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int COUNT_BITS_DEFAULT = 10;
    localparam int CFG_W              = 10;
    localparam int CFG_INDEX_W        = 3;
    localparam int SWITCH_MISS_LIMIT  = 200;
    localparam int STATE_CODE_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_HITS           = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOSS_LIMIT             = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPECIAL_LOSS_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPECIAL_CONFIRM_HITS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPECIAL_MISS_TOLERANCE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANT_MODE          = 3'd5;

    localparam logic [CFG_W-1:0] RST_CONFIRM_HITS           = 10'd3;
    localparam logic [CFG_W-1:0] RST_LOSS_LIMIT             = 10'd15;
    localparam logic [CFG_W-1:0] RST_SPECIAL_LOSS_LIMIT     = 10'd75;
    localparam logic [CFG_W-1:0] RST_SPECIAL_CONFIRM_HITS   = 10'd3;
    localparam logic [CFG_W-1:0] RST_SPECIAL_MISS_TOLERANCE = 10'd8;

    localparam logic [STATE_CODE_W-1:0] CODE_LOST      = 3'd0;
    localparam logic [STATE_CODE_W-1:0] CODE_DETECTING = 3'd1;
    localparam logic [STATE_CODE_W-1:0] CODE_TRACKING  = 3'd2;
    localparam logic [STATE_CODE_W-1:0] CODE_COASTING  = 3'd3;
    localparam logic [STATE_CODE_W-1:0] CODE_SWITCHING = 3'd4;

    typedef enum logic [4:0] {
        MODE_LOST      = 5'b00001,
        MODE_DETECTING = 5'b00010,
        MODE_TRACKING  = 5'b00100,
        MODE_COASTING  = 5'b01000,
        MODE_SWITCHING = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [CFG_W-1:0] confirm_hits;
        logic [CFG_W-1:0] loss_limit;
        logic [CFG_W-1:0] special_loss_limit;
        logic [CFG_W-1:0] special_confirm_hits;
        logic [CFG_W-1:0] special_miss_tolerance;
        logic             tolerant_mode;
    } t_cfg;

    typedef struct packed {
        logic found;
        logic is_special;
        logic long_gap;
        logic request_switch;
        logic diverged;
        logic bad_converge;
    } t_frame;

    typedef struct packed {
        logic [STATE_CODE_W-1:0] track_state;
        logic                    target_valid;
    } t_result;

    function automatic logic [STATE_CODE_W-1:0] mode_code(input t_mode m);
        logic [STATE_CODE_W-1:0] c;
        case (m)
            MODE_DETECTING: c = CODE_DETECTING;
            MODE_TRACKING:  c = CODE_TRACKING;
            MODE_COASTING:  c = CODE_COASTING;
            MODE_SWITCHING: c = CODE_SWITCHING;
            default:        c = CODE_LOST;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/tcf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Track confirmation configuration registers
// Holds the confirmation counts, loss limits, special miss tolerance and tolerant mode bit, written
// through the configuration channel.
// ----------------------------------------------------------------------------
module tcf_cfg_regs
    import tcf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_hits           <= RST_CONFIRM_HITS;
            r_cfg.loss_limit             <= RST_LOSS_LIMIT;
            r_cfg.special_loss_limit     <= RST_SPECIAL_LOSS_LIMIT;
            r_cfg.special_confirm_hits   <= RST_SPECIAL_CONFIRM_HITS;
            r_cfg.special_miss_tolerance <= RST_SPECIAL_MISS_TOLERANCE;
            r_cfg.tolerant_mode          <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CONFIRM_HITS:           r_cfg.confirm_hits           <= i_cfg_data;
                CFG_LOSS_LIMIT:             r_cfg.loss_limit             <= i_cfg_data;
                CFG_SPECIAL_LOSS_LIMIT:     r_cfg.special_loss_limit     <= i_cfg_data;
                CFG_SPECIAL_CONFIRM_HITS:   r_cfg.special_confirm_hits   <= i_cfg_data;
                CFG_SPECIAL_MISS_TOLERANCE: r_cfg.special_miss_tolerance <= i_cfg_data;
                CFG_TOLERANT_MODE:          r_cfg.tolerant_mode          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/tcf_tracker.sv -----
// ----------------------------------------------------------------------------
// Track confirmation state tracker
// Holds the track mode and its counters and computes one frame's update
// combinationally; the new state is registered on each step.
// ----------------------------------------------------------------------------
module tcf_tracker
    import tcf_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_frame  i_frame,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    t_mode                 r_mode;
    t_mode                 n_mode;
    t_mode                 mid_mode;
    logic [COUNT_BITS-1:0] r_hit;
    logic [COUNT_BITS-1:0] n_hit;
    logic [COUNT_BITS-1:0] r_miss_det;
    logic [COUNT_BITS-1:0] n_miss_det;
    logic [COUNT_BITS-1:0] r_miss;
    logic [COUNT_BITS-1:0] n_miss;
    logic                  hit;
    logic [CFG_W-1:0]      need;
    logic [CFG_W-1:0]      lim;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : COUNT_BITS'(v + 1'b1);
    endfunction

    always_comb begin
        n_hit      = r_hit;
        n_miss_det = r_miss_det;
        n_miss     = r_miss;
        hit        = i_frame.found;
        need       = i_cfg.confirm_hits;
        lim        = i_frame.is_special ? i_cfg.special_loss_limit : i_cfg.loss_limit;

        mid_mode = i_frame.long_gap ? MODE_LOST : r_mode;
        if (i_frame.request_switch && mid_mode == MODE_TRACKING) begin
            mid_mode = MODE_SWITCHING;
            hit      = 1'b0;
        end

        n_mode = mid_mode;
        case (mid_mode)
            MODE_LOST: begin
                if (hit) begin
                    n_mode     = MODE_DETECTING;
                    n_hit      = COUNT_BITS'(1);
                    n_miss_det = '0;
                end
            end
            MODE_DETECTING: begin
                if (hit) begin
                    n_hit = sat_inc(r_hit);
                    if (i_cfg.tolerant_mode) begin
                        n_miss_det = '0;
                        if (i_frame.is_special) begin
                            need = i_cfg.special_confirm_hits;
                        end
                    end
                    if (CMP_W'(n_hit) >= CMP_W'(need)) begin
                        n_mode = MODE_TRACKING;
                    end
                end else if (i_cfg.tolerant_mode && i_frame.is_special) begin
                    n_miss_det = sat_inc(r_miss_det);
                    if (CMP_W'(n_miss_det) > CMP_W'(i_cfg.special_miss_tolerance)) begin
                        n_hit      = '0;
                        n_miss_det = '0;
                        n_mode     = MODE_LOST;
                    end
                end else begin
                    n_hit  = '0;
                    n_mode = MODE_LOST;
                end
            end
            MODE_TRACKING: begin
                if (!hit) begin
                    n_miss = COUNT_BITS'(1);
                    n_mode = MODE_COASTING;
                end
            end
            MODE_SWITCHING: begin
                if (hit) begin
                    n_mode = MODE_DETECTING;
                end else begin
                    n_miss = sat_inc(r_miss);
                    if (CMP_W'(n_miss) > CMP_W'(SWITCH_MISS_LIMIT)) begin
                        n_mode = MODE_LOST;
                    end
                end
            end
            MODE_COASTING: begin
                if (hit) begin
                    n_mode = MODE_TRACKING;
                    n_miss = '0;
                end else begin
                    n_miss = sat_inc(r_miss);
                    if (CMP_W'(n_miss) > CMP_W'(lim)) begin
                        n_mode = MODE_LOST;
                    end
                end
            end
            default: begin
                n_mode = MODE_LOST;
            end
        endcase

        if (i_frame.diverged) begin
            n_mode = MODE_LOST;
        end
        if (i_frame.bad_converge && n_mode == MODE_TRACKING) begin
            n_mode = MODE_LOST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_LOST;
            r_hit      <= '0;
            r_miss_det <= '0;
            r_miss     <= '0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_hit      <= n_hit;
            r_miss_det <= n_miss_det;
            r_miss     <= n_miss;
        end
    end

    assign o_result.track_state  = mode_code(n_mode);
    assign o_result.target_valid = (n_mode != MODE_LOST);

endmodule

// ----- rtl/track_confirmation_fsm_core.sv -----
// ----------------------------------------------------------------------------
// Track confirmation state machine
// Per-frame track manager with lost, detecting, tracking, coasting and
// switching states and configurable confirmation and loss limits.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one frame's outcome flags and
// produces exactly one result on the master stream with the new track
// state and a target valid flag. A request is registered on acceptance,
// evaluated against the stored track state, and the result is registered,
// so the result is offered on the master side from the result register.
// One request is taken per cycle while the receiver does not stall; the
// state update is combinational and sees the previous frame's state before
// the next.
// When the receiver stalls, the result register holds its item and one
// more request can still be taken into the input register; further
// requests are held off until the result is taken.
// The configuration channel is always ready and should only be written
// while no request is in flight. Reset clears the state to lost, all
// counters to zero and the configuration registers to their default values.
// ----------------------------------------------------------------------------
module track_confirmation_fsm_core
    import tcf_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Bits from 0: found, is_special, long_gap, request_switch, diverged,
    // bad_converge, two unused bits.
    input  logic [7:0]             i_s_axis_tdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // Bits from 0: track_state (3), target_valid (1), four zero bits.
    output logic [7:0]             o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_cfg    cfg;
    t_result result;
    t_frame  r_frame;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;
    logic    step;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;

    tcf_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tcf_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_frame  (r_frame),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_frame.found          <= i_s_axis_tdata[0];
            r_frame.is_special     <= i_s_axis_tdata[1];
            r_frame.long_gap       <= i_s_axis_tdata[2];
            r_frame.request_switch <= i_s_axis_tdata[3];
            r_frame.diverged       <= i_s_axis_tdata[4];
            r_frame.bad_converge   <= i_s_axis_tdata[5];
        end
        if (step) begin
            r_result <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_result.target_valid, r_result.track_state};

endmodule
